[rtl/orqa_pkg.sv]
package orqa_pkg;

    // Field widths fixed by the item format.
    localparam int TAG_W  = 32;
    localparam int YEAR_W = 16;

    // Default ring depth.
    localparam int CAPACITY_DEF = 5;

    // The rounded mean always fits in 16 unsigned bits before the sign is applied.
    localparam int QUOT_W = 16;

    // Quotient bits resolved per divider cycle.
    localparam int DIV_STEPS = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic KIND_MEAN    = 1'b0;
    localparam logic KIND_REMOVED = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [TAG_W-1:0]         entry_tag;
        logic signed [YEAR_W-1:0] year_value;
    } t_in_item;

    typedef struct packed {
        logic                     result_kind;
        logic signed [YEAR_W-1:0] mean_year;
        logic                     evicted;
        logic [TAG_W-1:0]         removed_tag;
        logic signed [YEAR_W-1:0] removed_year;
    } t_out_item;

    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic signed [YEAR_W-1:0] year;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

[rtl/orqa_ram.sv]
module orqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/orqa_div.sv]
module orqa_div
    import orqa_pkg::*;
#(
    parameter int DEN_W = 4,
    localparam int NUM_W = DEN_W + QUOT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    // The caller guarantees the quotient fits in QUOT_W bits, so the upper
    // numerator bits are already below the divisor and seed the remainder.
    localparam int ITERS = QUOT_W / DIV_STEPS;
    localparam int CW    = (ITERS > 1) ? $clog2(ITERS) : 1;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [QUOT_W-1:0] r_num, n_num;
    logic [DEN_W-1:0]  r_den, n_den;

    logic [DEN_W:0]    trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_den  = r_den;
        trial  = '0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num[NUM_W-1:QUOT_W];
            n_num  = i_num[QUOT_W-1:0];
            n_den  = i_den;
        end else if (r_busy) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                trial = {n_rem, n_num[QUOT_W-1]};
                if (trial >= {1'b0, r_den}) begin
                    trial = trial - {1'b0, r_den};
                    n_num = {n_num[QUOT_W-2:0], 1'b1};
                end else begin
                    n_num = {n_num[QUOT_W-2:0], 1'b0};
                end
                n_rem = trial[DEN_W-1:0];
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(ITERS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

[rtl/overwrite_ring_queue_with_average.sv]
// Ring queue of CAPACITY entries, each a 32-bit tag and a signed 16-bit year.
// Input channel (i_in_valid / o_in_ready, i_in_item) takes one command per
// item: an insert appends an entry, dropping the oldest one first when the
// ring is full, and returns the mean of the held years rounded half away from
// zero; a remove pops the head entry and returns its tag and year. A remove
// on an empty ring is consumed and gives no result.
// Output channel (o_out_valid / i_out_ready, o_out_item) is driven from a
// register, so a waiting result never blocks the acceptance of the next item.
// A remove passes through a fetch state and a put state before its result
// is registered at the output. An insert passes through a launch state, the
// divide state and the put state, with a fetch state first when an entry is
// dropped; the mean comes from a shared divider resolving two quotient bits
// per cycle. One item is processed at a time.
// After a synchronous reset the ring is empty, the running sum is zero and no
// result is pending. If the receiver stalls, a finished result waits in a
// holding register, and the block takes no further item until it can move on.
module overwrite_ring_queue_with_average
    import orqa_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Sum of up to CAPACITY signed years: the year width plus room for the count.
    localparam int SUM_W = YEAR_W + CNT_W;
    localparam int DEN_W = CNT_W + 1;
    localparam int NUM_W = DEN_W + QUOT_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FETCH  = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_PUT    = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_head, n_head;
    logic [IDX_W-1:0]         r_tail, n_tail;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic                     r_op, n_op;
    logic [TAG_W-1:0]         r_tag, n_tag;
    logic signed [YEAR_W-1:0] r_year, n_year;
    logic                     r_evict, n_evict;
    t_out_item                r_res, n_res;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;

    logic                     in_acc;
    logic                     full;
    logic                     ram_we;
    t_slot                    ram_wdata;
    t_slot                    ram_rdata;
    logic                     div_start;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;
    logic [SUM_W-1:0]         sum_mag;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic signed [SUM_W-1:0]  in_year_ext;
    logic signed [SUM_W-1:0]  r_year_ext;
    logic signed [SUM_W-1:0]  rd_year_ext;
    logic [QUOT_W-1:0]        mean_bits;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(CAPACITY - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(CAPACITY));

    assign in_year_ext = {{(SUM_W - YEAR_W){i_in_item.year_value[YEAR_W-1]}},
                          i_in_item.year_value};
    assign r_year_ext  = {{(SUM_W - YEAR_W){r_year[YEAR_W-1]}}, r_year};
    assign rd_year_ext = {{(SUM_W - YEAR_W){ram_rdata.year[YEAR_W-1]}}, ram_rdata.year};

    // Entry store. The head is read every cycle; only the sequencer's fetch
    // state uses that data, once the registered read has settled on the head.
    // Items are handled one at a time, so the fetch state never uses a read
    // that overlapped a write of the same entry.
    assign ram_we = (in_acc && i_in_item.operation == OP_INSERT && !full)
                 || (r_state == S_FETCH && r_op == OP_INSERT);

    always_comb begin
        if (r_state == S_IDLE) begin
            ram_wdata.tag  = i_in_item.entry_tag;
            ram_wdata.year = i_in_item.year_value;
        end else begin
            ram_wdata.tag  = r_tag;
            ram_wdata.year = r_year;
        end
    end

    orqa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // Rounded mean: q = (2|sum| + n) / (2n), sign of the sum applied after.
    assign sum_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign div_num   = {sum_mag, 1'b0} + NUM_W'(r_count);
    assign div_den   = {r_count, 1'b0};
    assign div_start = (r_state == S_LAUNCH);

    orqa_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign mean_bits = r_sum[SUM_W-1] ? QUOT_W'(-div_quot) : div_quot;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_sum       = r_sum;
        n_op        = r_op;
        n_tag       = r_tag;
        n_year      = r_year;
        n_evict     = r_evict;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op   = i_in_item.operation;
                    n_tag  = i_in_item.entry_tag;
                    n_year = i_in_item.year_value;
                    if (i_in_item.operation == OP_INSERT) begin
                        if (full) begin
                            // The oldest year must be read before it is dropped.
                            n_evict = 1'b1;
                            n_state = S_FETCH;
                        end else begin
                            n_evict = 1'b0;
                            n_sum   = r_sum + in_year_ext;
                            n_count = r_count + CNT_W'(1);
                            n_tail  = ring_next(r_tail);
                            n_state = S_LAUNCH;
                        end
                    end else if (r_count != '0) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_head = ring_next(r_head);
                if (r_op == OP_INSERT) begin
                    // Full ring: head and tail coincide, the new entry lands
                    // in the slot just vacated.
                    n_sum   = r_sum - rd_year_ext + r_year_ext;
                    n_tail  = ring_next(r_tail);
                    n_state = S_LAUNCH;
                end else begin
                    n_sum                = r_sum - rd_year_ext;
                    n_count              = r_count - CNT_W'(1);
                    n_res.result_kind    = KIND_REMOVED;
                    n_res.mean_year      = '0;
                    n_res.evicted        = 1'b0;
                    n_res.removed_tag    = ram_rdata.tag;
                    n_res.removed_year   = ram_rdata.year;
                    n_state              = S_PUT;
                end
            end
            S_LAUNCH: begin
                n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (div_done) begin
                    n_res.result_kind  = KIND_MEAN;
                    n_res.mean_year    = mean_bits;
                    n_res.evicted      = r_evict;
                    n_res.removed_tag  = '0;
                    n_res.removed_year = '0;
                    n_state            = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_op    <= n_op;
        r_tag   <= n_tag;
        r_year  <= n_year;
        r_evict <= n_evict;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[rtl/orqa_checker.sv]
module orqa_checker
    import orqa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // A stalled result keeps its place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or vanished");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // Items are processed one at a time: an insert always occupies the block.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.operation == OP_INSERT |=> !o_in_ready)
        else $error("second item taken while an insert is in progress");

    // Fields that carry no meaning for a result kind are zero.
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_item.result_kind == KIND_MEAN
                && o_out_item.removed_tag == '0 && o_out_item.removed_year == '0)
         || (o_out_item.result_kind == KIND_REMOVED
                && o_out_item.mean_year == '0 && !o_out_item.evicted))
        else $error("unused result fields not cleared");

    // An insert always yields a result: the block is still busy when the insert has left its first state.
    a_insert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.operation == OP_INSERT
            |=> ##1 !o_in_ready)
        else $error("insert finished too early");

endmodule

bind overwrite_ring_queue_with_average orqa_checker u_orqa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
